/* hw/rtl/screen_power_and_charge_events_defines.svh */
// Assertion macros shared by the screen power and charge event block.
// Depends on nothing; expects signals named clock and reset in the including scope.
`ifndef SCREEN_POWER_AND_CHARGE_EVENTS_DEFINES_SVH
`define SCREEN_POWER_AND_CHARGE_EVENTS_DEFINES_SVH

// same-cycle implication, masked during reset
`define SPCE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spce assertion failed");

// next-cycle implication, masked during reset
`define SPCE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spce assertion failed");

`endif

/* hw/rtl/spce_pkg.sv */
// Shared types, constants and helpers for the screen power and charge event block.
// Depends on nothing.
package spce_pkg;

   localparam int unsigned POLL_TICKS       = 10;
   localparam int unsigned TICKS_PER_SECOND = 5;
   localparam int unsigned RESET_TIMEOUT    = 30;

   localparam int TIMEOUT_W   = 12;
   localparam int IDLE_W      = 16;
   localparam int LIMIT_W     = TIMEOUT_W + 7;
   localparam int POLL_W      = 8;
   localparam int MV_W        = 13;
   localparam int PCT_W       = 7;
   localparam int SPCT_W      = 8;
   localparam int MAX_RESULTS = 3;
   localparam int SLOT_W      = 2;

   localparam logic [IDLE_W-1:0]        IDLE_MAX     = '1;
   localparam logic signed [SPCT_W-1:0] PERCENT_NONE = -8'sd1;

   typedef enum logic [2:0] {
      EV_SCREEN_OFF   = 3'd0,
      EV_SCREEN_ON    = 3'd1,
      EV_UPDATE       = 3'd2,
      EV_CHARGE_START = 3'd3,
      EV_CHARGE_DONE  = 3'd4,
      EV_VBUS_OFF     = 3'd5
   } event_code_type;

   typedef struct packed {
      logic present;
      logic vbus;
      logic charging;
      logic full;
   } flags_type;

   typedef struct packed {
      logic [MV_W-1:0]          millivolts;
      logic signed [SPCT_W-1:0] percent;
      flags_type                flags;
   } status_type;

   typedef struct packed {
      logic             user_activity;
      logic             request_off;
      logic             request_on;
      logic             touch_line;
      logic             sample_ok;
      logic [MV_W-1:0]  millivolts;
      logic [PCT_W-1:0] percent;
      flags_type        flags;
   } item_type;

   typedef struct packed {
      logic              screen_off;
      logic              wake_pending;
      logic [IDLE_W-1:0] idle;
      logic [POLL_W-1:0] poll;
      status_type        status;
   } state_type;

   typedef struct packed {
      event_code_type code;
      logic           screen_off;
      status_type     status;
   } result_type;

   localparam state_type STATE_RESET = '{
      screen_off:   1'b0,
      wake_pending: 1'b0,
      idle:         '0,
      poll:         '0,
      status:       '{millivolts: '0, percent: PERCENT_NONE, flags: '0}
   };

   // idle tick threshold for a timeout in seconds; zero disables the auto off
   function automatic logic [LIMIT_W-1:0] timeout_limit(logic [TIMEOUT_W-1:0] seconds);
      return LIMIT_W'(seconds) * LIMIT_W'(TICKS_PER_SECOND);
   endfunction

   localparam logic [LIMIT_W-1:0] RESET_LIMIT = LIMIT_W'(RESET_TIMEOUT * TICKS_PER_SECOND);

endpackage

/* hw/rtl/spce_tick_eval.sv */
// Per-tick decision logic: screen requests, touch wake, idle timeout, battery poll.
// Depends on spce_pkg.
module spce_tick_eval
   import spce_pkg::*;
(
   input  state_type                         cur,
   input  item_type                          item,
   input  logic [LIMIT_W-1:0]                limit,
   output state_type                         nxt,
   output result_type [MAX_RESULTS-1:0]      slots,
   output logic [SLOT_W-1:0]                 count
);

   function automatic result_type make_result(event_code_type c, logic o, status_type s);
      result_type r;
      r.code       = c;
      r.screen_off = o;
      r.status     = s;
      return r;
   endfunction

   always_comb begin
      logic [SLOT_W-1:0] n;
      logic [POLL_W-1:0] poll_inc;
      flags_type         prev;
      event_code_type    bcode;

      nxt   = cur;
      slots = '0;
      n     = '0;
      prev  = cur.status.flags;
      bcode = EV_UPDATE;

      // idle count: clear on activity, otherwise count up and saturate
      if (item.user_activity) begin
         nxt.idle = '0;
      end else if (cur.idle != IDLE_MAX) begin
         nxt.idle = cur.idle + 1'b1;
      end

      if (item.request_off && !nxt.screen_off) begin
         nxt.screen_off   = 1'b1;
         nxt.wake_pending = 1'b0;
         slots[n] = make_result(EV_SCREEN_OFF, 1'b1, nxt.status);
         n = n + 1'b1;
      end

      // activity counts as an on request only if the tick began with the screen off
      if ((item.request_on || (item.user_activity && cur.screen_off)) && nxt.screen_off) begin
         nxt.screen_off = 1'b0;
         nxt.idle       = '0;
         slots[n] = make_result(EV_SCREEN_ON, 1'b0, nxt.status);
         n = n + 1'b1;
      end

      if (nxt.screen_off) begin
         if (!item.touch_line) begin
            if (nxt.wake_pending) begin
               nxt.wake_pending = 1'b0;
               nxt.screen_off   = 1'b0;
               nxt.idle         = '0;
               slots[n] = make_result(EV_SCREEN_ON, 1'b0, nxt.status);
               n = n + 1'b1;
            end else begin
               nxt.wake_pending = 1'b1;
            end
         end else begin
            nxt.wake_pending = 1'b0;
         end
      end else if ((limit != '0) && (LIMIT_W'(nxt.idle) >= limit)) begin
         nxt.screen_off   = 1'b1;
         nxt.wake_pending = 1'b0;
         slots[n] = make_result(EV_SCREEN_OFF, 1'b1, nxt.status);
         n = n + 1'b1;
      end

      poll_inc = cur.poll + 1'b1;
      if (poll_inc >= POLL_W'(POLL_TICKS)) begin
         nxt.poll = '0;
         if (item.sample_ok) begin
            nxt.status.millivolts = item.millivolts;
            nxt.status.percent    = item.flags.present ? SPCT_W'(item.percent) : PERCENT_NONE;
            nxt.status.flags      = item.flags;
            if ((!prev.vbus && item.flags.vbus) || (!prev.charging && item.flags.charging)) begin
               bcode = EV_CHARGE_START;
            end else if (!prev.full && item.flags.full) begin
               bcode = EV_CHARGE_DONE;
            end else if (prev.vbus && !item.flags.vbus) begin
               bcode = EV_VBUS_OFF;
            end
            slots[n] = make_result(bcode, nxt.screen_off, nxt.status);
            n = n + 1'b1;
         end
      end else begin
         nxt.poll = poll_inc;
      end

      count = n;
   end

endmodule

/* hw/rtl/screen_power_and_charge_events.sv */
// Top level of the screen power and charge event block: input register, tick
// evaluation, result buffer and the configuration register. Depends on spce_pkg,
// spce_tick_eval and screen_power_and_charge_events_defines.svh.

// One transaction on the req_ channel is one 200 ms tick. A tick gives zero to three
// result transactions on the rsp_ channel (screen off/on events, then at most one
// battery event), the final one flagged by rsp_last_of_tick; a tick with no screen
// change and no valid battery sample at the poll gives none. An accepted tick waits in
// the input register, is evaluated in a single pass into a three-entry result buffer,
// and the buffer drains one result per cycle while rsp_stall is low. The input register
// can take one more tick while results drain and holds it until the final one leaves.
// A tick's results pass from the input register into the result buffer once the buffer
// is free. The result port is the bottleneck.
// csr_wr_data sets the screen timeout in seconds (0 disables the auto off, reset
// value 30); a write also clears the idle count. Write it only while no tick is in
// flight.
`include "screen_power_and_charge_events_defines.svh"

module screen_power_and_charge_events
   import spce_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_user_activity,
   input  logic                     req_request_off,
   input  logic                     req_request_on,
   input  logic                     req_touch_line,
   input  logic                     req_sample_ok,
   input  logic [MV_W-1:0]          req_sample_millivolts,
   input  logic [PCT_W-1:0]         req_sample_percent,
   input  logic                     req_sample_present,
   input  logic                     req_sample_vbus,
   input  logic                     req_sample_charging,
   input  logic                     req_sample_full,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_event_code,
   output logic                     rsp_last_of_tick,
   output logic                     rsp_screen_is_off,
   output logic [MV_W-1:0]          rsp_status_millivolts,
   output logic signed [SPCT_W-1:0] rsp_status_percent,
   output logic                     rsp_status_present,
   output logic                     rsp_status_vbus,
   output logic                     rsp_status_charging,
   output logic                     rsp_status_full,

   input  logic                     csr_wr_en,
   input  logic [TIMEOUT_W-1:0]     csr_wr_data
);

   // input register
   logic                         in_valid_ff, in_valid_in;
   item_type                     in_item_ff,  in_item_in;

   // block state and timeout threshold
   state_type                    state_ff,    state_in;
   logic [LIMIT_W-1:0]           limit_ff,    limit_in;

   // result buffer
   logic                         out_valid_ff, out_valid_in;
   result_type [MAX_RESULTS-1:0] out_slots_ff, out_slots_in;
   logic [SLOT_W-1:0]            out_count_ff, out_count_in;
   logic [SLOT_W-1:0]            out_idx_ff,   out_idx_in;

   // evaluation outputs
   state_type                    eval_state;
   result_type [MAX_RESULTS-1:0] eval_slots;
   logic [SLOT_W-1:0]            eval_count;

   logic       accept;
   logic       advance;
   logic       out_take;
   logic       out_last;
   result_type cur_result;

   spce_tick_eval u_eval (
      .cur   (state_ff),
      .item  (in_item_ff),
      .limit (limit_ff),
      .nxt   (eval_state),
      .slots (eval_slots),
      .count (eval_count)
   );

   // handshake: the held tick moves on once the buffer is empty or its final result leaves
   assign cur_result = out_slots_ff[out_idx_ff];
   assign out_last   = (out_idx_ff == out_count_ff - 1'b1);
   assign out_take   = out_valid_ff && !rsp_stall;
   assign advance    = in_valid_ff && (!out_valid_ff || (out_take && out_last));
   assign req_stall  = in_valid_ff && !advance;
   assign accept     = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      state_in     = state_ff;
      limit_in     = limit_ff;
      out_valid_in = out_valid_ff;
      out_slots_in = out_slots_ff;
      out_count_in = out_count_ff;
      out_idx_in   = out_idx_ff;

      // capture a new tick, or drop the one that moved on
      if (accept) begin
         in_valid_in = 1'b1;
         in_item_in  = '{
            user_activity: req_user_activity,
            request_off:   req_request_off,
            request_on:    req_request_on,
            touch_line:    req_touch_line,
            sample_ok:     req_sample_ok,
            millivolts:    req_sample_millivolts,
            percent:       req_sample_percent,
            flags:         '{present:  req_sample_present,
                             vbus:     req_sample_vbus,
                             charging: req_sample_charging,
                             full:     req_sample_full}
         };
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      // commit the tick: update state and load its results
      if (advance) begin
         state_in     = eval_state;
         out_valid_in = (eval_count != '0);
         out_slots_in = eval_slots;
         out_count_in = eval_count;
         out_idx_in   = '0;
      end else if (out_take) begin
         if (out_last) begin
            out_valid_in = 1'b0;
         end else begin
            out_idx_in = out_idx_ff + 1'b1;
         end
      end

      // a timeout write restarts the idle count
      if (csr_wr_en) begin
         limit_in      = timeout_limit(csr_wr_data);
         state_in.idle = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
         limit_ff     <= RESET_LIMIT;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         limit_ff     <= limit_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_item_ff   <= in_item_in;
      out_slots_ff <= out_slots_in;
      out_count_ff <= out_count_in;
      out_idx_ff   <= out_idx_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_event_code        = cur_result.code;
   assign rsp_last_of_tick      = out_last;
   assign rsp_screen_is_off     = cur_result.screen_off;
   assign rsp_status_millivolts = cur_result.status.millivolts;
   assign rsp_status_percent    = cur_result.status.percent;
   assign rsp_status_present    = cur_result.status.flags.present;
   assign rsp_status_vbus       = cur_result.status.flags.vbus;
   assign rsp_status_charging   = cur_result.status.flags.charging;
   assign rsp_status_full       = cur_result.status.flags.full;

   // the read pointer stays inside the loaded results
   `SPCE_ASSERT_NOW(a_idx_in_range, out_valid_ff, out_idx_ff < out_count_ff)
   // stall the input only while a tick is held
   `SPCE_ASSERT_NOW(a_stall_needs_tick, req_stall, in_valid_ff)
   // no battery means the stored percent reads as minus one
   `SPCE_ASSERT_NOW(a_percent_none, !state_ff.status.flags.present,
                    state_ff.status.percent == PERCENT_NONE)
   // a timeout write always leaves the idle count cleared
   `SPCE_ASSERT_NEXT(a_csr_clears_idle, csr_wr_en, state_ff.idle == '0)

endmodule

/* bench/screen_power_and_charge_events_test.sv */
// Self-checking bench for screen_power_and_charge_events: directed and random ticks
// against a local predictor of the screen and battery event logic.
// Depends on spce_pkg and the screen_power_and_charge_events RTL.
`timescale 1ns / 100ps

module screen_power_and_charge_events_test;
   import spce_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 7;
   localparam int SETTLE_CYCLES  = 10;    // time for the last tick to clear the input register and the buffer
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction on either channel
   localparam int IDLE_PERCENT   = 15;
   localparam int MAX_REPORTS    = 10;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_TICKS    = 37;

   // one expected or observed result of the block
   typedef struct packed {
      event_code_type           code;
      logic                     last;
      logic                     screen_off;
      logic [MV_W-1:0]          millivolts;
      logic signed [SPCT_W-1:0] percent;
      flags_type                flags;
   } screen_event_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_user_activity = 1'b0;
   logic                     req_request_off = 1'b0;
   logic                     req_request_on = 1'b0;
   logic                     req_touch_line = 1'b1;
   logic                     req_sample_ok = 1'b0;
   logic [MV_W-1:0]          req_sample_millivolts = '0;
   logic [PCT_W-1:0]         req_sample_percent = '0;
   logic                     req_sample_present = 1'b0;
   logic                     req_sample_vbus = 1'b0;
   logic                     req_sample_charging = 1'b0;
   logic                     req_sample_full = 1'b0;

   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [2:0]               rsp_event_code;
   logic                     rsp_last_of_tick;
   logic                     rsp_screen_is_off;
   logic [MV_W-1:0]          rsp_status_millivolts;
   logic signed [SPCT_W-1:0] rsp_status_percent;
   logic                     rsp_status_present;
   logic                     rsp_status_vbus;
   logic                     rsp_status_charging;
   logic                     rsp_status_full;

   logic                     csr_wr_en = 1'b0;
   logic [TIMEOUT_W-1:0]     csr_wr_data = '0;

   // predictor state, starting from the reset values of the block
   logic [TIMEOUT_W-1:0]     timeout_seconds = TIMEOUT_W'(RESET_TIMEOUT);
   logic                     screen_dark = 1'b0;
   logic                     wake_armed = 1'b0;
   logic [IDLE_W-1:0]        idle_count = '0;
   logic [POLL_W-1:0]        poll_count = '0;
   logic [MV_W-1:0]          held_mv = '0;
   logic signed [SPCT_W-1:0] held_pct = PERCENT_NONE;
   flags_type                held_flags = '0;
   int                       tick_results;

   screen_event_type         pending_events[$];
   int                       failures = 0;
   int                       quiet_cycles = 0;
   bit                       calm = 1'b0;      // set to suppress idling on both sides
   item_type                 base_tick = '0;   // sample fields carried by directed ticks

   screen_event_type         seen_event;
   screen_event_type         want_event;
   string                    diff_fields;

   screen_power_and_charge_events u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_user_activity     (req_user_activity),
      .req_request_off       (req_request_off),
      .req_request_on        (req_request_on),
      .req_touch_line        (req_touch_line),
      .req_sample_ok         (req_sample_ok),
      .req_sample_millivolts (req_sample_millivolts),
      .req_sample_percent    (req_sample_percent),
      .req_sample_present    (req_sample_present),
      .req_sample_vbus       (req_sample_vbus),
      .req_sample_charging   (req_sample_charging),
      .req_sample_full       (req_sample_full),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_event_code        (rsp_event_code),
      .rsp_last_of_tick      (rsp_last_of_tick),
      .rsp_screen_is_off     (rsp_screen_is_off),
      .rsp_status_millivolts (rsp_status_millivolts),
      .rsp_status_percent    (rsp_status_percent),
      .rsp_status_present    (rsp_status_present),
      .rsp_status_vbus       (rsp_status_vbus),
      .rsp_status_charging   (rsp_status_charging),
      .rsp_status_full       (rsp_status_full),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // queue one result carrying the current status snapshot
   task automatic post_event(input event_code_type code);
      screen_event_type ev;
      ev.code       = code;
      ev.last       = 1'b0;
      ev.screen_off = screen_dark;
      ev.millivolts = held_mv;
      ev.percent    = held_pct;
      ev.flags      = held_flags;
      pending_events.push_back(ev);
      tick_results++;
   endtask

   task automatic blank_screen();
      screen_dark = 1'b1;
      wake_armed  = 1'b0;
      post_event(EV_SCREEN_OFF);
   endtask

   task automatic light_screen();
      screen_dark = 1'b0;
      idle_count  = '0;
      post_event(EV_SCREEN_ON);
   endtask

   // work out every result that one accepted tick causes
   task automatic predict_tick_events(input item_type it);
      logic               was_dark;
      logic [LIMIT_W-1:0] off_limit;
      flags_type          prev_flags;
      event_code_type     poll_code;
      tick_results = 0;
      was_dark     = screen_dark;

      // idle count: clear on activity, otherwise count up and saturate
      if (it.user_activity)
         idle_count = '0;
      else if (idle_count != IDLE_MAX)
         idle_count = idle_count + 1'b1;

      // requests: off first, then on; activity on a dark screen counts as on
      if (it.request_off && !screen_dark)
         blank_screen();
      if ((it.request_on || (it.user_activity && was_dark)) && screen_dark)
         light_screen();

      if (screen_dark) begin
         // two low touch samples in a row wake the screen
         if (!it.touch_line) begin
            if (wake_armed) begin
               wake_armed = 1'b0;
               light_screen();
            end else begin
               wake_armed = 1'b1;
            end
         end else begin
            wake_armed = 1'b0;
         end
      end else if (timeout_seconds != '0) begin
         off_limit = LIMIT_W'(timeout_seconds) * LIMIT_W'(TICKS_PER_SECOND);
         if (LIMIT_W'(idle_count) >= off_limit)
            blank_screen();
      end

      // battery poll: restart the divider even when the sample is invalid
      poll_count = poll_count + 1'b1;
      if (poll_count >= POLL_W'(POLL_TICKS)) begin
         poll_count = '0;
         if (it.sample_ok) begin
            prev_flags = held_flags;
            held_mv    = it.millivolts;
            held_flags = it.flags;
            held_pct   = it.flags.present ? $signed({1'b0, it.percent}) : PERCENT_NONE;
            if ((!prev_flags.vbus && it.flags.vbus) ||
                (!prev_flags.charging && it.flags.charging))
               poll_code = EV_CHARGE_START;
            else if (!prev_flags.full && it.flags.full)
               poll_code = EV_CHARGE_DONE;
            else if (prev_flags.vbus && !it.flags.vbus)
               poll_code = EV_VBUS_OFF;
            else
               poll_code = EV_UPDATE;
            post_event(poll_code);
         end
      end

      // mark the final result of this tick; none of them can have drained yet
      if (tick_results > 0)
         pending_events[pending_events.size() - 1].last = 1'b1;
   endtask

   // ---------------------------------------------------------------- drivers

   // send one tick, holding it until accepted, then advance the predictor
   task automatic send_tick(input item_type it);
      if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < IDLE_PERCENT);
      end
      req_valid             <= 1'b1;
      req_user_activity     <= it.user_activity;
      req_request_off       <= it.request_off;
      req_request_on        <= it.request_on;
      req_touch_line        <= it.touch_line;
      req_sample_ok         <= it.sample_ok;
      req_sample_millivolts <= it.millivolts;
      req_sample_percent    <= it.percent;
      req_sample_present    <= it.flags.present;
      req_sample_vbus       <= it.flags.vbus;
      req_sample_charging   <= it.flags.charging;
      req_sample_full       <= it.flags.full;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_tick_events(it);
   endtask

   // drop valid, wait for every expected result, then let the pipeline empty
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_events.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [TIMEOUT_W-1:0] seconds);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= seconds;
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      timeout_seconds = seconds;
      idle_count      = '0;
   endtask

   // directed tick: control bits given, sample fields taken from base_tick
   function automatic item_type tick_of(input logic activity, input logic off_req,
                                        input logic on_req, input logic touch);
      item_type it;
      it               = base_tick;
      it.user_activity = activity;
      it.request_off   = off_req;
      it.request_on    = on_req;
      it.touch_line    = touch;
      return it;
   endfunction

   // random tick, biased towards realistic battery readings
   function automatic item_type random_tick();
      item_type it;
      it.user_activity = ($urandom_range(99) < 12);
      it.request_off   = ($urandom_range(99) < 10);
      it.request_on    = ($urandom_range(99) < 8);
      it.touch_line    = ($urandom_range(99) >= 35);
      it.sample_ok     = ($urandom_range(99) < 85);
      if ($urandom_range(3) == 0)
         it.millivolts = MV_W'($urandom_range(8191));
      else
         it.millivolts = MV_W'($urandom_range(4400, 3000));
      if ($urandom_range(9) == 0)
         it.percent = PCT_W'($urandom_range(127, 101));
      else
         it.percent = PCT_W'($urandom_range(100));
      it.flags = flags_type'(4'($urandom_range(15)));
      return it;
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic string describe(input screen_event_type ev);
      return $sformatf("code=%0d last=%0b off=%0b mv=%0d pct=%0d pvcf=%b%b%b%b",
                       ev.code, ev.last, ev.screen_off, ev.millivolts, ev.percent,
                       ev.flags.present, ev.flags.vbus, ev.flags.charging, ev.flags.full);
   endfunction

   task automatic note_failure(input string what);
      failures++;
      if (failures <= MAX_REPORTS)
         $display("mismatch at %0t: %s", $time, what);
   endtask

   // receiver stalls at random unless calm
   always @(posedge clock)
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);

   // compare each accepted result with the oldest expectation, field by field
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_event.code             = event_code_type'(rsp_event_code);
         seen_event.last             = rsp_last_of_tick;
         seen_event.screen_off       = rsp_screen_is_off;
         seen_event.millivolts       = rsp_status_millivolts;
         seen_event.percent          = rsp_status_percent;
         seen_event.flags.present    = rsp_status_present;
         seen_event.flags.vbus       = rsp_status_vbus;
         seen_event.flags.charging   = rsp_status_charging;
         seen_event.flags.full       = rsp_status_full;
         if (pending_events.size() == 0) begin
            note_failure({"unexpected result ", describe(seen_event)});
         end else begin
            want_event  = pending_events.pop_front();
            diff_fields = "";
            if (seen_event.code != want_event.code)
               diff_fields = {diff_fields, " event_code"};
            if (seen_event.last != want_event.last)
               diff_fields = {diff_fields, " last_of_tick"};
            if (seen_event.screen_off != want_event.screen_off)
               diff_fields = {diff_fields, " screen_is_off"};
            if (seen_event.millivolts != want_event.millivolts)
               diff_fields = {diff_fields, " millivolts"};
            if (seen_event.percent != want_event.percent)
               diff_fields = {diff_fields, " percent"};
            if (seen_event.flags.present != want_event.flags.present)
               diff_fields = {diff_fields, " present"};
            if (seen_event.flags.vbus != want_event.flags.vbus)
               diff_fields = {diff_fields, " vbus"};
            if (seen_event.flags.charging != want_event.flags.charging)
               diff_fields = {diff_fields, " charging"};
            if (seen_event.flags.full != want_event.flags.full)
               diff_fields = {diff_fields, " full"};
            if (diff_fields != "")
               note_failure({"fields", diff_fields, ": expected ", describe(want_event),
                             " actual ", describe(seen_event)});
         end
      end
   end

   // watchdog: end the run if neither channel moves a transaction for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", pending_events.size());
         $display("screen_power_and_charge_events_test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   // all-zero and all-one ticks; the all-one tick turns off and on in one go
   task automatic test_field_extremes();
      item_type it;
      it = '0;
      send_tick(it);
      it = '1;
      send_tick(it);
   endtask

   // off and on requests, redundant ones and activity waking a dark screen
   task automatic test_screen_requests();
      base_tick            = '0;
      base_tick.sample_ok  = 1'b1;
      base_tick.millivolts = MV_W'(3900);
      base_tick.percent    = PCT_W'(64);
      base_tick.flags      = '{present: 1'b1, vbus: 1'b1, charging: 1'b0, full: 1'b0};
      send_tick(tick_of(1'b0, 1'b0, 1'b1, 1'b1));   // on while already on
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b1));   // off
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b1));   // off while already off
      send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b1));   // activity wakes
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b1));   // off
      send_tick(tick_of(1'b0, 1'b0, 1'b1, 1'b1));   // on request
   endtask

   // a dark screen needs two low touch samples in a row; a high one disarms
   task automatic test_touch_wake();
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b0));   // off, then first low sample
      send_tick(tick_of(1'b0, 1'b0, 1'b0, 1'b1));   // high clears the arming
      send_tick(tick_of(1'b0, 1'b0, 1'b0, 1'b0));
      send_tick(tick_of(1'b0, 1'b0, 1'b0, 1'b0));   // second low wakes
   endtask

   // auto off at the shortest timeout; a register write clears idle but never wakes
   task automatic test_idle_timeout();
      int n;
      base_tick.sample_ok     = 1'b0;
      base_tick.flags.present = 1'b0;
      write_timeout(TIMEOUT_W'(1));
      for (n = 0; n < TICKS_PER_SECOND; n++)
         send_tick(tick_of(1'b0, 1'b0, 1'b0, 1'b1));
      write_timeout('0);
      send_tick(tick_of(1'b0, 1'b0, 1'b0, 1'b1));
      send_tick(tick_of(1'b0, 1'b0, 1'b0, 1'b1));
      send_tick(tick_of(1'b0, 1'b0, 1'b1, 1'b1));
   endtask

   // random ticks over several timeout settings, one phase without idling
   task automatic test_random_traffic();
      int                   phase;
      int                   n;
      logic [TIMEOUT_W-1:0] phase_timeout;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       phase_timeout = TIMEOUT_W'(2);
            1:       phase_timeout = '0;
            2:       phase_timeout = '1;
            3:       phase_timeout = TIMEOUT_W'(1);
            4:       phase_timeout = TIMEOUT_W'(3600);
            default: phase_timeout = TIMEOUT_W'($urandom_range(3, 1));
         endcase
         write_timeout(phase_timeout);
         calm = (phase == 2);
         for (n = 0; n < PHASE_TICKS; n++)
            send_tick(random_tick());
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_screen_requests();
      test_touch_wake();
      test_idle_timeout();
      test_random_traffic();
      wait_drained();
      if (failures == 0 && pending_events.size() == 0)
         $display("screen_power_and_charge_events_test passed");
      else
         $display("screen_power_and_charge_events_test failed");
      $finish;
   end

endmodule
